/* hw/rtl/slfp_pkg.sv */
// Package for the sync/length frame parser.
// Holds register indexes, reset values, status codes and shared structs.
// No dependencies.
package slfp_pkg;

  localparam int unsigned CountBitsDef = 7;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 8;
  localparam int unsigned PosBits      = 7;

  localparam logic [7:0] FirstSyncRst  = 8'hA5;
  localparam logic [7:0] SecondSyncRst = 8'h5A;
  localparam logic [6:0] LenPosRst     = 7'd8;
  localparam logic [6:0] HdrSizeRst    = 7'd9;
  localparam logic [6:0] MaxFrameRst   = 7'd120;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFirstSync  = 3'd0,
    CfgSecondSync = 3'd1,
    CfgLenPos     = 3'd2,
    CfgHdrSize    = 3'd3,
    CfgMaxFrame   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StDiscard   = 3'd0,
    StInFrame   = 3'd1,
    StComplete  = 3'd2,
    StBadSync   = 3'd3,
    StOverlength = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] first_sync;
    logic [7:0] second_sync;
    logic [6:0] length_position;
    logic [6:0] header_size;
    logic [6:0] max_frame;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic [PosBits-1:0] position;
    status_e            status;
    logic [PosBits-1:0] frame_length;
  } res_t;

endpackage

/* hw/rtl/slfp_cfg_regs.sv */
// Configuration register file of the frame parser.
// Depends on slfp_pkg for register indexes, reset values and cfg_t.
module slfp_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [slfp_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [slfp_pkg::CfgDataBits-1:0] cfg_data_i,
  output slfp_pkg::cfg_t                  cfg_o
);
  import slfp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFirstSync:  cfg_d.first_sync      = cfg_data_i;
        CfgSecondSync: cfg_d.second_sync     = cfg_data_i;
        CfgLenPos:     cfg_d.length_position = cfg_data_i[6:0];
        CfgHdrSize:    cfg_d.header_size     = cfg_data_i[6:0];
        CfgMaxFrame:   cfg_d.max_frame       = cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_sync      <= FirstSyncRst;
      cfg_q.second_sync     <= SecondSyncRst;
      cfg_q.length_position <= LenPosRst;
      cfg_q.header_size     <= HdrSizeRst;
      cfg_q.max_frame       <= MaxFrameRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/slfp_parse_core.sv */
// Framing logic: byte counter, latched length and per-word status decode.
// Depends on slfp_pkg for cfg_t, res_t and status codes.
module slfp_parse_core #(
  parameter int unsigned COUNT_BITS = slfp_pkg::CountBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     rx_byte_i,
  input  slfp_pkg::cfg_t cfg_i,
  output slfp_pkg::res_t res_o
);
  import slfp_pkg::*;

  localparam int unsigned CmpBits = (COUNT_BITS + 1 > 9) ? COUNT_BITS + 1 : 9;
  localparam logic [CmpBits-1:0] CountMax = CmpBits'((1 << COUNT_BITS) - 1);

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [7:0]            length_q, length_d;

  logic [CmpBits-1:0] pos_w, cnt_w, lp_w, sum_w;
  logic [7:0]         len_eff;
  logic               len_hit;
  status_e            status;
  logic [PosBits-1:0] flen;

  always_comb begin
    pos_w   = CmpBits'(count_q);
    cnt_w   = pos_w + CmpBits'(1);
    lp_w    = CmpBits'(cfg_i.length_position);
    len_hit = (pos_w == lp_w);
    len_eff = len_hit ? rx_byte_i : length_q;
    sum_w   = CmpBits'(len_eff) + CmpBits'(cfg_i.header_size);

    count_d  = count_q;
    length_d = length_q;
    status   = StInFrame;
    flen     = '0;

    if (pos_w == '0 && rx_byte_i != cfg_i.first_sync) begin
      status = StDiscard;
    end else if (pos_w == CmpBits'(1) && rx_byte_i != cfg_i.second_sync) begin
      status  = StBadSync;
      count_d = '0;
    end else begin
      length_d = len_eff;
      count_d  = cnt_w[COUNT_BITS-1:0];
      if (cnt_w > lp_w && cnt_w == sum_w) begin
        status  = StComplete;
        flen    = cnt_w[PosBits-1:0];
        count_d = '0;
      end else if (cnt_w >= CmpBits'(cfg_i.max_frame) || cnt_w >= CountMax) begin
        status  = StOverlength;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      length_q <= '0;
    end else if (step_i) begin
      count_q  <= count_d;
      length_q <= length_d;
    end
  end

  assign res_o.data_byte    = rx_byte_i;
  assign res_o.position     = pos_w[PosBits-1:0];
  assign res_o.status       = status;
  assign res_o.frame_length = flen;

endmodule

/* hw/rtl/sync_length_frame_parser.sv */
// Sync/length frame parser top level: input register, framing core, result register.
// Words pass the input register and then the result register; one word per cycle
// while the output is not stalled, set by the single compare-and-count step between them.
// Reset: asynchronous active low; clears counter, length, valid flags, and loads
// the configuration defaults.
// Depends on slfp_pkg, slfp_cfg_regs and slfp_parse_core.
module sync_length_frame_parser #(
  parameter int unsigned COUNT_BITS = slfp_pkg::CountBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [slfp_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [slfp_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       data_byte_o,
  output logic [slfp_pkg::PosBits-1:0]     position_o,
  output logic [2:0]                       status_o,
  output logic [slfp_pkg::PosBits-1:0]     frame_length_o
);
  import slfp_pkg::*;

  cfg_t cfg;
  res_t res;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  res_t       out_q;
  logic       advance;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  slfp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  slfp_parse_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign data_byte_o    = out_q.data_byte;
  assign position_o     = out_q.position;
  assign status_o       = out_q.status;
  assign frame_length_o = out_q.frame_length;

endmodule
